// ----- rtl/core/gtg_pkg.sv -----
// shared types, constants and angle table for the go-to-goal pose controller
package gtg_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;

    localparam int POS_W    = 16;
    localparam int DIFF_W   = POS_W + 1;
    localparam int SQ_W     = 2 * POS_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int SQRT_STEPS = (SUM_W + 1) / 2;
    localparam int ROOT_W   = SQRT_STEPS;
    localparam int SQRT_W   = SUM_W + 2;

    localparam int CX_W     = 28;
    localparam int ANG_W    = 24;
    localparam int ANG_FRAC = 20;
    localparam int BEAR_SH  = 8;
    localparam int BEAR_W   = ANG_W - BEAR_SH;

    localparam int GAIN_W   = 8;
    localparam int HGAIN_W  = 4;
    localparam int SPD_PROD_W = GAIN_W + ROOT_W;
    localparam int SPD_W    = 16;
    localparam int TURN_DIFF_W = POS_W + 2;
    localparam int TURN_PROD_W = TURN_DIFF_W + HGAIN_W + 1;
    localparam int TURN_W   = 20;

    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(1647099);
    localparam logic signed [TURN_W-1:0] TURN_MAX   = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN   = {1'b1, {(TURN_W-1){1'b0}}};

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOAL_X       = 3'd0,
        CFG_GOAL_Y       = 3'd1,
        CFG_LINEAR_GAIN  = 3'd2,
        CFG_HEADING_GAIN = 3'd3,
        CFG_TOLERANCE    = 3'd4
    } t_cfg_index;

    localparam logic [GAIN_W-1:0]  LINEAR_GAIN_RST  = 8'd128;
    localparam logic [HGAIN_W-1:0] HEADING_GAIN_RST = 4'd4;
    localparam logic [POS_W-1:0]   TOLERANCE_RST    = 16'd3;

    // arctangent of 2^-i in units of 2^-20 rad
    function automatic logic [ANG_W-1:0] atan_val(input int unsigned i);
        logic [ANG_W-1:0] v;
        case (i)
            0: v = ANG_W'(823550);
            1: v = ANG_W'(486170);
            2: v = ANG_W'(256879);
            3: v = ANG_W'(130396);
            4: v = ANG_W'(65451);
            5: v = ANG_W'(32757);
            6: v = ANG_W'(16383);
            7: v = ANG_W'(8192);
            default: v = ANG_W'(32'd1048576 >> i);
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/gtg_isqrt.sv -----
// pipelined restoring integer square root, one result bit per step stage, later stages pass through
module gtg_isqrt #(
    parameter int DEPTH = gtg_pkg::SQRT_STEPS
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [gtg_pkg::SUM_W-1:0]     i_radicand,
    output logic [gtg_pkg::ROOT_W-1:0]    o_root
);

    localparam int W = gtg_pkg::SQRT_W;

    logic [W-1:0] r_n    [DEPTH];
    logic [W-1:0] r_root [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_stage
        logic [W-1:0] w_n_in;
        logic [W-1:0] w_r_in;
        logic [W-1:0] n_n;
        logic [W-1:0] n_root;

        if (k == 0) begin : g_first
            assign w_n_in = W'(i_radicand);
            assign w_r_in = '0;
        end else begin : g_next
            assign w_n_in = r_n[k-1];
            assign w_r_in = r_root[k-1];
        end

        if (k < gtg_pkg::SQRT_STEPS) begin : g_step
            localparam logic [W-1:0] BIT = W'(1) << (2 * (gtg_pkg::SQRT_STEPS - 1 - k));
            logic [W-1:0] w_trial;
            assign w_trial = w_r_in + BIT;
            always_comb begin
                if (w_n_in >= w_trial) begin
                    n_n    = w_n_in - w_trial;
                    n_root = (w_r_in >> 1) + BIT;
                end else begin
                    n_n    = w_n_in;
                    n_root = w_r_in >> 1;
                end
            end
        end else begin : g_pass
            assign n_n    = w_n_in;
            assign n_root = w_r_in;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]    <= n_n;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_root = r_root[DEPTH-1][gtg_pkg::ROOT_W-1:0];

endmodule

// ----- rtl/core/gtg_cordic.sv -----
// pipelined cordic vectoring, one rotation per stage up to ITERATIONS, later stages pass through; returns the angle
module gtg_cordic #(
    parameter int ITERATIONS = gtg_pkg::CORDIC_ITERATIONS_DEF,
    parameter int DEPTH      = gtg_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [gtg_pkg::CX_W-1:0]    i_x,
    input  logic signed [gtg_pkg::CX_W-1:0]    i_y,
    input  logic signed [gtg_pkg::ANG_W-1:0]   i_z,
    output logic signed [gtg_pkg::ANG_W-1:0]   o_z
);

    localparam int XW = gtg_pkg::CX_W;
    localparam int ZW = gtg_pkg::ANG_W;

    logic signed [XW-1:0] r_x [DEPTH];
    logic signed [XW-1:0] r_y [DEPTH];
    logic signed [ZW-1:0] r_z [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_stage
        logic signed [XW-1:0] w_x;
        logic signed [XW-1:0] w_y;
        logic signed [ZW-1:0] w_z;
        logic signed [XW-1:0] n_x;
        logic signed [XW-1:0] n_y;
        logic signed [ZW-1:0] n_z;

        if (k == 0) begin : g_first
            assign w_x = i_x;
            assign w_y = i_y;
            assign w_z = i_z;
        end else begin : g_next
            assign w_x = r_x[k-1];
            assign w_y = r_y[k-1];
            assign w_z = r_z[k-1];
        end

        if (k < ITERATIONS) begin : g_rot
            localparam logic signed [ZW-1:0] ATAN = gtg_pkg::atan_val(k);
            logic signed [XW-1:0] w_xs;
            logic signed [XW-1:0] w_ys;
            assign w_xs = w_x >>> k;
            assign w_ys = w_y >>> k;
            always_comb begin
                if (!w_y[XW-1]) begin
                    n_x = w_x + w_ys;
                    n_y = w_y - w_xs;
                    n_z = w_z + ATAN;
                end else begin
                    n_x = w_x - w_ys;
                    n_y = w_y + w_xs;
                    n_z = w_z - ATAN;
                end
            end
        end else begin : g_pass
            assign n_x = w_x;
            assign n_y = w_y;
            assign n_z = w_z;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= n_x;
                r_y[k] <= n_y;
                r_z[k] <= n_z;
            end
        end
    end

    assign o_z = r_z[DEPTH-1];

endmodule

// ----- rtl/core/go_to_goal_pose_controller.sv -----
// Go-to-goal controller: per pose sample, distance and bearing to the goal
// give a saturated speed command and a saturated turn command (zero and
// arrived when within tolerance). One sample is accepted every cycle
// while the output register is empty or being taken, and the whole
// pipeline advances under that condition, so a stall holds every stage.
// Each result passes the offset, square and sum stages, the square root and
// cordic lanes side by side (LANE stages each), then gain and output stages.
module go_to_goal_pose_controller #(
    parameter int CORDIC_ITERATIONS = gtg_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gtg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // pose samples
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [47:0]                         s_axis_tdata,  // pos_x, pos_y, heading
    // commands
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [39:0]                         m_axis_tdata,  // linear_velocity, turn_rate, zero pad
    output logic                                m_axis_tuser   // arrived
);

    localparam int PW    = gtg_pkg::POS_W;
    localparam int DW    = gtg_pkg::DIFF_W;
    localparam int XW    = gtg_pkg::CX_W;
    localparam int ZW    = gtg_pkg::ANG_W;
    localparam int LANE  = (gtg_pkg::SQRT_STEPS > CORDIC_ITERATIONS) ?
                           gtg_pkg::SQRT_STEPS : CORDIC_ITERATIONS;

    // configuration registers
    logic signed [PW-1:0]                r_goal_x;
    logic signed [PW-1:0]                r_goal_y;
    logic [gtg_pkg::GAIN_W-1:0]          r_lin_gain;
    logic [gtg_pkg::HGAIN_W-1:0]         r_head_gain;
    logic [PW-1:0]                       r_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_lin_gain  <= gtg_pkg::LINEAR_GAIN_RST;
            r_head_gain <= gtg_pkg::HEADING_GAIN_RST;
            r_tol       <= gtg_pkg::TOLERANCE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                gtg_pkg::CFG_GOAL_X:       r_goal_x    <= i_cfg_data;
                gtg_pkg::CFG_GOAL_Y:       r_goal_y    <= i_cfg_data;
                gtg_pkg::CFG_LINEAR_GAIN:  r_lin_gain  <= i_cfg_data[gtg_pkg::GAIN_W-1:0];
                gtg_pkg::CFG_HEADING_GAIN: r_head_gain <= i_cfg_data[gtg_pkg::HGAIN_W-1:0];
                gtg_pkg::CFG_TOLERANCE:    r_tol       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline enable
    logic r_out_valid;
    logic w_en;
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    logic signed [PW-1:0] w_pos_x;
    logic signed [PW-1:0] w_pos_y;
    assign w_pos_x = s_axis_tdata[15:0];
    assign w_pos_y = s_axis_tdata[31:16];

    // stage a: offsets to goal
    logic                 r_a_valid;
    logic signed [DW-1:0] r_a_dx;
    logic signed [DW-1:0] r_a_dy;
    logic signed [PW-1:0] r_a_hd;

    // stage b: squares
    logic                 r_b_valid;
    logic signed [DW-1:0] r_b_dx;
    logic signed [DW-1:0] r_b_dy;
    logic signed [PW-1:0] r_b_hd;
    logic [gtg_pkg::SQ_W-1:0] r_b_dx2;
    logic [gtg_pkg::SQ_W-1:0] r_b_dy2;
    logic [gtg_pkg::SQ_W-1:0] r_b_tol2;

    // stage c: sum, arrival test, cordic pre-rotation
    logic                      r_c_valid;
    logic [gtg_pkg::SUM_W-1:0] r_c_sum;
    logic                      r_c_arrived;
    logic signed [PW-1:0]      r_c_hd;
    logic signed [XW-1:0]      r_c_x;
    logic signed [XW-1:0]      r_c_y;
    logic signed [ZW-1:0]      r_c_z;

    logic signed [2*DW-1:0] w_dx2;
    logic signed [2*DW-1:0] w_dy2;
    logic [gtg_pkg::SUM_W-1:0] w_sum;
    logic signed [XW-1:0]   w_x0;
    logic signed [XW-1:0]   w_y0;
    logic signed [XW-1:0]   n_c_x;
    logic signed [XW-1:0]   n_c_y;
    logic signed [ZW-1:0]   n_c_z;

    assign w_dx2 = (2*DW)'(r_a_dx) * (2*DW)'(r_a_dx);
    assign w_dy2 = (2*DW)'(r_a_dy) * (2*DW)'(r_a_dy);
    assign w_sum = gtg_pkg::SUM_W'(r_b_dx2) + gtg_pkg::SUM_W'(r_b_dy2);
    assign w_x0  = XW'(r_b_dx) <<< 8;
    assign w_y0  = XW'(r_b_dy) <<< 8;

    always_comb begin
        n_c_x = w_x0;
        n_c_y = w_y0;
        n_c_z = '0;
        if (w_x0[XW-1]) begin
            if (!w_y0[XW-1]) begin
                n_c_x = w_y0;
                n_c_y = -w_x0;
                n_c_z = gtg_pkg::ANG_HALF_PI;
            end else begin
                n_c_x = -w_y0;
                n_c_y = w_x0;
                n_c_z = -gtg_pkg::ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= s_axis_tvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_dx      <= DW'(r_goal_x) - DW'(w_pos_x);
            r_a_dy      <= DW'(r_goal_y) - DW'(w_pos_y);
            r_a_hd      <= s_axis_tdata[47:32];
            r_b_dx      <= r_a_dx;
            r_b_dy      <= r_a_dy;
            r_b_hd      <= r_a_hd;
            r_b_dx2     <= w_dx2[gtg_pkg::SQ_W-1:0];
            r_b_dy2     <= w_dy2[gtg_pkg::SQ_W-1:0];
            r_b_tol2    <= gtg_pkg::SQ_W'(r_tol) * gtg_pkg::SQ_W'(r_tol);
            r_c_sum     <= w_sum;
            r_c_arrived <= (w_sum <= gtg_pkg::SUM_W'(r_b_tol2));
            r_c_hd      <= r_b_hd;
            r_c_x       <= n_c_x;
            r_c_y       <= n_c_y;
            r_c_z       <= n_c_z;
        end
    end

    // distance and bearing lanes
    logic [gtg_pkg::ROOT_W-1:0] w_dist;
    logic signed [ZW-1:0]       w_angle;

    gtg_isqrt #(
        .DEPTH      (LANE)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_radicand (r_c_sum),
        .o_root     (w_dist)
    );

    gtg_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS),
        .DEPTH      (LANE)
    ) u_cordic (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_x        (r_c_x),
        .i_y        (r_c_y),
        .i_z        (r_c_z),
        .o_z        (w_angle)
    );

    // side data alongside the lanes
    logic                 r_l_valid   [LANE];
    logic                 r_l_arrived [LANE];
    logic signed [PW-1:0] r_l_hd      [LANE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE; k++) begin
                r_l_valid[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_l_valid[0] <= r_c_valid;
            for (int k = 1; k < LANE; k++) begin
                r_l_valid[k] <= r_l_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l_arrived[0] <= r_c_arrived;
            r_l_hd[0]      <= r_c_hd;
            for (int k = 1; k < LANE; k++) begin
                r_l_arrived[k] <= r_l_arrived[k-1];
                r_l_hd[k]      <= r_l_hd[k-1];
            end
        end
    end

    // stage d: gains
    logic                                       r_d_valid;
    logic                                       r_d_arrived;
    logic [gtg_pkg::SPD_PROD_W-1:0]             r_d_spd;
    logic signed [gtg_pkg::TURN_PROD_W-1:0]     r_d_turn;

    logic signed [ZW-1:0]                       w_ang_rnd;
    logic signed [gtg_pkg::BEAR_W-1:0]          w_bearing;
    logic signed [gtg_pkg::TURN_DIFF_W-1:0]     w_err;
    logic signed [gtg_pkg::HGAIN_W:0]           w_hgain;

    assign w_ang_rnd = w_angle + ZW'(128);
    assign w_bearing = w_ang_rnd[ZW-1:gtg_pkg::BEAR_SH];
    assign w_err     = gtg_pkg::TURN_DIFF_W'(w_bearing)
                     - gtg_pkg::TURN_DIFF_W'(r_l_hd[LANE-1]);
    assign w_hgain   = {1'b0, r_head_gain};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_l_valid[LANE-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_arrived <= r_l_arrived[LANE-1];
            r_d_spd     <= gtg_pkg::SPD_PROD_W'(r_lin_gain)
                         * gtg_pkg::SPD_PROD_W'(w_dist);
            r_d_turn    <= gtg_pkg::TURN_PROD_W'(w_err)
                         * gtg_pkg::TURN_PROD_W'(w_hgain);
        end
    end

    // stage e: saturation and output register
    logic [gtg_pkg::SPD_W-1:0]          r_out_lv;
    logic signed [gtg_pkg::TURN_W-1:0]  r_out_turn;
    logic                               r_out_arrived;
    logic [gtg_pkg::SPD_W-1:0]          n_out_lv;
    logic signed [gtg_pkg::TURN_W-1:0]  n_out_turn;
    logic [gtg_pkg::SPD_PROD_W-9:0]     w_spd_sh;

    assign w_spd_sh = r_d_spd[gtg_pkg::SPD_PROD_W-1:8];

    always_comb begin
        n_out_lv   = w_spd_sh[gtg_pkg::SPD_W-1:0];
        n_out_turn = r_d_turn[gtg_pkg::TURN_W-1:0];
        if (w_spd_sh[gtg_pkg::SPD_PROD_W-9:gtg_pkg::SPD_W] != '0) begin
            n_out_lv = '1;
        end
        if (r_d_turn > gtg_pkg::TURN_PROD_W'(gtg_pkg::TURN_MAX)) begin
            n_out_turn = gtg_pkg::TURN_MAX;
        end else if (r_d_turn < gtg_pkg::TURN_PROD_W'(gtg_pkg::TURN_MIN)) begin
            n_out_turn = gtg_pkg::TURN_MIN;
        end
        if (r_d_arrived) begin
            n_out_lv   = '0;
            n_out_turn = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_lv      <= n_out_lv;
            r_out_turn    <= n_out_turn;
            r_out_arrived <= r_d_arrived;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_turn, r_out_lv};
    assign m_axis_tuser  = r_out_arrived;

    // checks
    a_arrived_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[35:0] == '0))
        else $error("arrived result carries nonzero commands");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_a_valid)
        else $error("accepted request did not enter the pipeline");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_valid && w_en) |=> r_out_valid)
        else $error("result lost between gain stage and output");

endmodule
